@@ hw/rtl/midi_pad_note_tracker_defines.svh @@
// assertion helpers for the tracker rtl, included by mpnt_seq
`ifndef MIDI_PAD_NOTE_TRACKER_DEFINES_SVH
`define MIDI_PAD_NOTE_TRACKER_DEFINES_SVH

// same-cycle implication
`define MPNT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpnt same-cycle check failed");

// next-cycle implication
`define MPNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpnt next-cycle check failed");

`endif

@@ hw/rtl/mpnt_pkg.sv @@
package mpnt_pkg;

   localparam int PAD_W      = 5;
   localparam int NOTE_W     = 7;
   localparam int CHAN_W     = 5;
   localparam int CIN_W      = 4;
   localparam int STATUS_W   = 8;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [1:0] {
      KIND_NOTE_ON  = 2'd0,
      KIND_NOTE_OFF = 2'd1,
      KIND_ALL_OFF  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_CHANNEL  = 2'd1,
      CSR_VELOCITY = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OFF_RD,
      ST_SWEEP,
      ST_SWEEP_RD
   } state_type;

   localparam logic [CIN_W-1:0]    CIN_NOTE_ON  = 4'd9;
   localparam logic [CIN_W-1:0]    CIN_NOTE_OFF = 4'd8;
   localparam logic [CIN_W-1:0]    CIN_CTRL     = 4'd11;
   localparam logic [STATUS_W-1:0] MSG_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] MSG_NOTE_OFF = 8'h80;
   localparam logic [STATUS_W-1:0] MSG_CTRL     = 8'hB0;
   localparam logic [NOTE_W-1:0]   CC_ALL_OFF   = 7'd123;
   localparam logic [CHAN_W-1:0]   CHAN_MAX     = 5'd16;

   typedef struct packed {
      logic                  enable;
      logic [CHAN_W-1:0]     channel;
      logic [NOTE_W-1:0]     velocity;
   } cfg_type;

   typedef struct packed {
      logic [CIN_W-1:0]      code_index;
      logic [STATUS_W-1:0]   status_byte;
      logic [NOTE_W-1:0]     data_one;
      logic [NOTE_W-1:0]     data_two;
      logic                  last;
   } pkt_type;

endpackage

@@ hw/rtl/mpnt_note_ram.sv @@
module mpnt_note_ram #(
   parameter int DEPTH = 24,
   parameter int AW    = 5
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [AW-1:0]                addr,
   input  logic [mpnt_pkg::NOTE_W-1:0]  wr_data,
   output logic [mpnt_pkg::NOTE_W-1:0]  rd_data
);

   logic [mpnt_pkg::NOTE_W-1:0] note_mem [DEPTH];
   logic [mpnt_pkg::NOTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem[addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= note_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mpnt_seq.sv @@
`include "midi_pad_note_tracker_defines.svh"

module mpnt_seq #(
   parameter int NUM_PADS = 24,
   parameter int AW       = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mpnt_pkg::cfg_type            cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_kind,
   input  logic [mpnt_pkg::PAD_W-1:0]   req_pad,
   input  logic [mpnt_pkg::NOTE_W-1:0]  req_mapped_note,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mpnt_pkg::pkt_type            rsp_pkt,
   output logic                         ram_we,
   output logic                         ram_re,
   output logic [AW-1:0]                ram_addr,
   output logic [mpnt_pkg::NOTE_W-1:0]  ram_wdata,
   input  logic [mpnt_pkg::NOTE_W-1:0]  ram_rdata
);

   localparam int CntW = $clog2(NUM_PADS + 1);

   mpnt_pkg::state_type     state_ff, state_in;
   logic [NUM_PADS-1:0]     pad_active_ff, pad_active_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic                    rsp_valid_ff;
   mpnt_pkg::pkt_type       pkt_ff;

   logic                          out_free;
   logic                          out_load;
   mpnt_pkg::pkt_type             load_pkt;
   logic                          req_acc;
   logic                          pad_ok;
   logic [AW-1:0]                 pidx;
   logic [AW-1:0]                 cidx;
   logic                          sweep_done;
   logic [3:0]                    chan_m1;
   logic [mpnt_pkg::STATUS_W-1:0] chan_bits;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == mpnt_pkg::ST_IDLE) && out_free;
   assign req_acc    = req_valid && req_ready;
   assign pad_ok     = {1'b0, req_pad} < (mpnt_pkg::PAD_W + 1)'(NUM_PADS);
   assign pidx       = req_pad[AW-1:0];
   assign cidx       = cnt_ff[AW-1:0];
   assign sweep_done = cnt_ff == CntW'(NUM_PADS);

   // channel clamped to 1..16, then minus one
   always_comb begin
      if (cfg.channel == '0) begin
         chan_m1 = 4'd0;
      end else if (cfg.channel > mpnt_pkg::CHAN_MAX) begin
         chan_m1 = 4'd15;
      end else begin
         chan_m1 = 4'(cfg.channel - 5'd1);
      end
   end
   assign chan_bits = {4'd0, chan_m1};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpnt_pkg::ST_IDLE: begin
            if (req_acc && cfg.enable) begin
               case (req_kind)
                  mpnt_pkg::KIND_NOTE_OFF: begin
                     if (pad_ok && pad_active_ff[pidx]) begin
                        state_in = mpnt_pkg::ST_OFF_RD;
                     end
                  end
                  mpnt_pkg::KIND_ALL_OFF: begin
                     state_in = mpnt_pkg::ST_SWEEP;
                  end
                  default: begin
                     state_in = mpnt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         mpnt_pkg::ST_OFF_RD: begin
            if (out_free) begin
               state_in = mpnt_pkg::ST_IDLE;
            end
         end
         mpnt_pkg::ST_SWEEP: begin
            if (sweep_done) begin
               if (out_free) begin
                  state_in = mpnt_pkg::ST_IDLE;
               end
            end else if (pad_active_ff[cidx]) begin
               state_in = mpnt_pkg::ST_SWEEP_RD;
            end
         end
         mpnt_pkg::ST_SWEEP_RD: begin
            if (out_free) begin
               state_in = mpnt_pkg::ST_SWEEP;
            end
         end
         default: begin
            state_in = mpnt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_addr      = pidx;
      ram_wdata     = req_mapped_note;
      pad_active_in = pad_active_ff;
      cnt_in        = cnt_ff;
      out_load      = 1'b0;
      load_pkt.code_index  = mpnt_pkg::CIN_NOTE_OFF;
      load_pkt.status_byte = mpnt_pkg::MSG_NOTE_OFF | chan_bits;
      load_pkt.data_one    = ram_rdata;
      load_pkt.data_two    = '0;
      load_pkt.last        = 1'b1;
      case (state_ff)
         mpnt_pkg::ST_IDLE: begin
            if (req_acc && cfg.enable) begin
               case (req_kind)
                  mpnt_pkg::KIND_NOTE_ON: begin
                     if (pad_ok) begin
                        ram_we               = 1'b1;
                        pad_active_in[pidx]  = 1'b1;
                        out_load             = 1'b1;
                        load_pkt.code_index  = mpnt_pkg::CIN_NOTE_ON;
                        load_pkt.status_byte = mpnt_pkg::MSG_NOTE_ON | chan_bits;
                        load_pkt.data_one    = req_mapped_note;
                        load_pkt.data_two    = cfg.velocity;
                     end
                  end
                  mpnt_pkg::KIND_NOTE_OFF: begin
                     if (pad_ok) begin
                        pad_active_in[pidx] = 1'b0;
                        if (pad_active_ff[pidx]) begin
                           ram_re = 1'b1;
                        end else begin
                           out_load          = 1'b1;
                           load_pkt.data_one = req_mapped_note;
                        end
                     end
                  end
                  mpnt_pkg::KIND_ALL_OFF: begin
                     cnt_in = '0;
                  end
                  default: begin
                     out_load = 1'b0;
                  end
               endcase
            end
         end
         mpnt_pkg::ST_OFF_RD: begin
            out_load = out_free;
         end
         mpnt_pkg::ST_SWEEP: begin
            if (sweep_done) begin
               out_load             = out_free;
               load_pkt.code_index  = mpnt_pkg::CIN_CTRL;
               load_pkt.status_byte = mpnt_pkg::MSG_CTRL | chan_bits;
               load_pkt.data_one    = mpnt_pkg::CC_ALL_OFF;
            end else if (pad_active_ff[cidx]) begin
               ram_re   = 1'b1;
               ram_addr = cidx;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         mpnt_pkg::ST_SWEEP_RD: begin
            if (out_free) begin
               out_load            = 1'b1;
               load_pkt.last       = 1'b0;
               pad_active_in[cidx] = 1'b0;
               cnt_in              = cnt_ff + 1'b1;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mpnt_pkg::ST_IDLE;
         pad_active_ff <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pad_active_ff <= pad_active_in;
         cnt_ff        <= cnt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         pkt_ff <= load_pkt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pkt   = pkt_ff;

   `MPNT_ASSERT_NEXT(a_note_on_sets_flag, clock, reset,
      req_acc && cfg.enable && pad_ok && (req_kind == mpnt_pkg::KIND_NOTE_ON),
      pad_active_ff[$past(pidx)])
   `MPNT_ASSERT_NOW(a_sweep_end_all_clear, clock, reset,
      (state_ff == mpnt_pkg::ST_SWEEP) && sweep_done, pad_active_ff == '0)
   `MPNT_ASSERT_NEXT(a_last_returns_idle, clock, reset,
      out_load && load_pkt.last, state_ff == mpnt_pkg::ST_IDLE)
   `MPNT_ASSERT_NOW(a_ram_single_access, clock, reset, 1'b1, !(ram_we && ram_re))

endmodule

@@ hw/rtl/midi_pad_note_tracker.sv @@
// note-on, and note-off of an idle pad, show a packet in the cycle after the transfer
// note-off of an active pad reads the note memory, then loads once the output is free
// all-notes-off walks the pads, skipping idle ones and reading the note of each active one
// for its note-off, then sends the control change; a new event is taken once done
// reset clears the active flags at once and restores enable, channel and velocity;
// the note memory is not cleared and is read only for active pads
module midi_pad_note_tracker #(
   parameter int NUM_PADS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [mpnt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [mpnt_pkg::PAD_W-1:0]       req_pad,
   input  logic [mpnt_pkg::NOTE_W-1:0]      req_mapped_note,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mpnt_pkg::CIN_W-1:0]       rsp_code_index,
   output logic [mpnt_pkg::STATUS_W-1:0]    rsp_status_byte,
   output logic [mpnt_pkg::NOTE_W-1:0]      rsp_data_one,
   output logic [mpnt_pkg::NOTE_W-1:0]      rsp_data_two,
   output logic                             rsp_last
);

   localparam int AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

   mpnt_pkg::cfg_type             cfg_ff;
   mpnt_pkg::pkt_type             rsp_pkt;
   logic                          ram_we;
   logic                          ram_re;
   logic [AW-1:0]                 ram_addr;
   logic [mpnt_pkg::NOTE_W-1:0]   ram_wdata;
   logic [mpnt_pkg::NOTE_W-1:0]   ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable   <= 1'b0;
         cfg_ff.channel  <= 5'd1;
         cfg_ff.velocity <= 7'd100;
      end else if (csr_we) begin
         case (csr_index)
            mpnt_pkg::CSR_ENABLE:   cfg_ff.enable   <= csr_wdata[0];
            mpnt_pkg::CSR_CHANNEL:  cfg_ff.channel  <= csr_wdata[mpnt_pkg::CHAN_W-1:0];
            mpnt_pkg::CSR_VELOCITY: cfg_ff.velocity <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   mpnt_seq #(
      .NUM_PADS (NUM_PADS),
      .AW       (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_pad         (req_pad),
      .req_mapped_note (req_mapped_note),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pkt         (rsp_pkt),
      .ram_we          (ram_we),
      .ram_re          (ram_re),
      .ram_addr        (ram_addr),
      .ram_wdata       (ram_wdata),
      .ram_rdata       (ram_rdata)
   );

   mpnt_note_ram #(
      .DEPTH (NUM_PADS),
      .AW    (AW)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rsp_code_index  = rsp_pkt.code_index;
   assign rsp_status_byte = rsp_pkt.status_byte;
   assign rsp_data_one    = rsp_pkt.data_one;
   assign rsp_data_two    = rsp_pkt.data_two;
   assign rsp_last        = rsp_pkt.last;

endmodule

@@ dv/tb_midi_pad_note_tracker.sv @@
module tb_midi_pad_note_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_COUNT = 24;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // time for a full sweep of every pad, with slack
   localparam int SETTLE_CYCLES = 2 * PAD_COUNT + 12;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_EVENTS = 64;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [mpnt_pkg::PAD_W-1:0]  pad;
      logic [mpnt_pkg::NOTE_W-1:0] note;
   } pad_event_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [1:0]                       csr_index = '0;
   logic [mpnt_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_kind = '0;
   logic [mpnt_pkg::PAD_W-1:0]       req_pad = '0;
   logic [mpnt_pkg::NOTE_W-1:0]      req_mapped_note = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [mpnt_pkg::CIN_W-1:0]       rsp_code_index;
   logic [mpnt_pkg::STATUS_W-1:0]    rsp_status_byte;
   logic [mpnt_pkg::NOTE_W-1:0]      rsp_data_one;
   logic [mpnt_pkg::NOTE_W-1:0]      rsp_data_two;
   logic                             rsp_last;

   pad_event_type                pad_events[$];
   mpnt_pkg::pkt_type            expected_packets[$];
   mpnt_pkg::pkt_type            seen_packet;
   mpnt_pkg::pkt_type            want_packet;
   mpnt_pkg::cfg_type            cfg;
   bit                           pad_sounding[PAD_COUNT];
   logic [mpnt_pkg::NOTE_W-1:0]  sounding_note[PAD_COUNT];
   bit                           steady = 1'b0;
   int                           errors = 0;
   int                           quiet_cycles = 0;

   midi_pad_note_tracker #(
      .NUM_PADS(PAD_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_pad(req_pad),
      .req_mapped_note(req_mapped_note),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_index(rsp_code_index),
      .rsp_status_byte(rsp_status_byte),
      .rsp_data_one(rsp_data_one),
      .rsp_data_two(rsp_data_two),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [mpnt_pkg::STATUS_W-1:0] status_for(
         logic [mpnt_pkg::STATUS_W-1:0] msg);
      logic [mpnt_pkg::CHAN_W-1:0] chan;
      chan = cfg.channel;
      if (chan == '0) chan = 5'd1;
      else if (chan > mpnt_pkg::CHAN_MAX) chan = mpnt_pkg::CHAN_MAX;
      return msg | mpnt_pkg::STATUS_W'(chan - 5'd1);
   endfunction

   function automatic void add_packet(logic [mpnt_pkg::CIN_W-1:0] cin,
                                      logic [mpnt_pkg::STATUS_W-1:0] msg,
                                      logic [mpnt_pkg::NOTE_W-1:0] d1,
                                      logic [mpnt_pkg::NOTE_W-1:0] d2);
      mpnt_pkg::pkt_type pkt;
      pkt.code_index = cin;
      pkt.status_byte = status_for(msg);
      pkt.data_one = d1;
      pkt.data_two = d2;
      pkt.last = 1'b0;
      expected_packets.push_back(pkt);
   endfunction

   // expected packets for one accepted pad event, updates the note table
   function automatic void predict_packets(pad_event_type ev);
      mpnt_pkg::pkt_type tail;
      if (!cfg.enable) return;
      case (ev.kind)
         mpnt_pkg::KIND_NOTE_ON: begin
            if (ev.pad >= PAD_COUNT) return;
            pad_sounding[ev.pad] = 1'b1;
            sounding_note[ev.pad] = ev.note;
            add_packet(mpnt_pkg::CIN_NOTE_ON, mpnt_pkg::MSG_NOTE_ON, ev.note, cfg.velocity);
         end
         mpnt_pkg::KIND_NOTE_OFF: begin
            if (ev.pad >= PAD_COUNT) return;
            add_packet(mpnt_pkg::CIN_NOTE_OFF, mpnt_pkg::MSG_NOTE_OFF,
                       pad_sounding[ev.pad] ? sounding_note[ev.pad] : ev.note, '0);
            pad_sounding[ev.pad] = 1'b0;
         end
         mpnt_pkg::KIND_ALL_OFF: begin
            for (int p = 0; p < PAD_COUNT; p++) begin
               if (pad_sounding[p]) begin
                  add_packet(mpnt_pkg::CIN_NOTE_OFF, mpnt_pkg::MSG_NOTE_OFF,
                             sounding_note[p], '0);
                  pad_sounding[p] = 1'b0;
               end
            end
            add_packet(mpnt_pkg::CIN_CTRL, mpnt_pkg::MSG_CTRL, mpnt_pkg::CC_ALL_OFF, '0);
         end
         default: return;
      endcase
      tail = expected_packets.pop_back();
      tail.last = 1'b1;
      expected_packets.push_back(tail);
   endfunction

   function automatic void note_failure(string what, mpnt_pkg::pkt_type want,
                                        mpnt_pkg::pkt_type got);
      errors++;
      if (errors <= 10)
         $display({"%0t %s: expected cin=%0d status=%02h d1=%0d d2=%0d last=%0d,",
                   " got cin=%0d status=%02h d1=%0d d2=%0d last=%0d"},
                  $time, what, want.code_index, want.status_byte, want.data_one,
                  want.data_two, want.last, got.code_index, got.status_byte,
                  got.data_one, got.data_two, got.last);
   endfunction

   function automatic void queue_event(logic [1:0] kind, int pad, int note);
      pad_event_type ev;
      ev.kind = kind;
      ev.pad = pad[mpnt_pkg::PAD_W-1:0];
      ev.note = note[mpnt_pkg::NOTE_W-1:0];
      pad_events.push_back(ev);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_packets({req_kind, req_pad, req_mapped_note});
         if (!req_valid || req_ready) begin
            if (pad_events.size() > 0 && (steady || $urandom_range(99) >= 38)) begin
               {req_kind, req_pad, req_mapped_note} <= pad_events.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // packet monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_packet.code_index = rsp_code_index;
            seen_packet.status_byte = rsp_status_byte;
            seen_packet.data_one = rsp_data_one;
            seen_packet.data_two = rsp_data_two;
            seen_packet.last = rsp_last;
            if (expected_packets.size() == 0) begin
               note_failure("packet with nothing expected", '0, seen_packet);
            end else begin
               want_packet = expected_packets.pop_front();
               if (seen_packet.code_index !== want_packet.code_index ||
                   seen_packet.status_byte !== want_packet.status_byte ||
                   seen_packet.data_one !== want_packet.data_one ||
                   seen_packet.data_two !== want_packet.data_two ||
                   seen_packet.last !== want_packet.last)
                  note_failure("packet mismatch", want_packet, seen_packet);
            end
         end
         rsp_ready <= steady || $urandom_range(99) >= 38;
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("midi_pad_note_tracker test failed");
         $finish;
      end
   end

   task automatic write_csr(mpnt_pkg::csr_index_type idx,
                            logic [mpnt_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mpnt_pkg::CSR_ENABLE:   cfg.enable = value[0];
         mpnt_pkg::CSR_CHANNEL:  cfg.channel = value[mpnt_pkg::CHAN_W-1:0];
         mpnt_pkg::CSR_VELOCITY: cfg.velocity = value;
         default: ;
      endcase
   endtask

   // wait for every event to be taken and every packet to arrive, then let a sweep finish
   // sampled at the falling edge so the driver's updates have settled
   task automatic settle();
      while (pad_events.size() > 0 || req_valid || expected_packets.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_events(int count);
      int roll;
      int pad;
      logic [1:0] kind;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 45) kind = mpnt_pkg::KIND_NOTE_ON;
         else if (roll < 80) kind = mpnt_pkg::KIND_NOTE_OFF;
         else if (roll < 92) kind = mpnt_pkg::KIND_ALL_OFF;
         else kind = KIND_UNUSED;
         // crowd most events onto a few pads so note-offs find sounding notes
         roll = $urandom_range(99);
         if (roll < 65) pad = $urandom_range(7);
         else if (roll < 90) pad = $urandom_range(PAD_COUNT - 1);
         else pad = $urandom_range(31, PAD_COUNT);
         queue_event(kind, pad, $urandom_range(127));
      end
   endtask

   initial begin
      cfg.enable = 1'b0;
      cfg.channel = 5'd1;
      cfg.velocity = 7'd100;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // disabled out of reset, nothing comes out
      queue_event(mpnt_pkg::KIND_NOTE_ON, 2, 64);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 2, 64);
      queue_event(mpnt_pkg::KIND_ALL_OFF, 0, 0);
      settle();

      write_csr(mpnt_pkg::CSR_ENABLE, 7'd1);
      write_csr(mpnt_pkg::CSR_CHANNEL, 7'd0);
      write_csr(mpnt_pkg::CSR_VELOCITY, 7'd127);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 0, 0);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 23, 127);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 24, 5);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 31, 85);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 31, 42);
      queue_event(KIND_UNUSED, 5, 9);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 0, 77);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 0, 77);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 5, 60);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 5, 61);
      queue_event(mpnt_pkg::KIND_ALL_OFF, 31, 127);
      queue_event(mpnt_pkg::KIND_ALL_OFF, 0, 0);
      settle();

      // channel above 16 clamps, zero velocity
      write_csr(mpnt_pkg::CSR_CHANNEL, 7'd31);
      write_csr(mpnt_pkg::CSR_VELOCITY, 7'd0);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 10, 42);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 9, 1);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 9, 3);
      queue_event(mpnt_pkg::KIND_ALL_OFF, 12, 100);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 7, 99);
      settle();

      // disabled: the sounding note on pad 7 must survive
      write_csr(mpnt_pkg::CSR_ENABLE, 7'd0);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 7, 5);
      queue_event(mpnt_pkg::KIND_NOTE_ON, 7, 6);
      queue_event(mpnt_pkg::KIND_ALL_OFF, 0, 0);
      queue_event(KIND_UNUSED, 7, 6);
      settle();
      write_csr(mpnt_pkg::CSR_ENABLE, 7'd1);
      write_csr(mpnt_pkg::CSR_CHANNEL, 7'd16);
      write_csr(mpnt_pkg::CSR_VELOCITY, 7'd64);
      queue_event(mpnt_pkg::KIND_NOTE_OFF, 7, 5);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) write_csr(mpnt_pkg::CSR_CHANNEL, 7'd17);
         else if (ph == 1) write_csr(mpnt_pkg::CSR_CHANNEL, 7'd1);
         else write_csr(mpnt_pkg::CSR_CHANNEL, 7'($urandom_range(31)));
         write_csr(mpnt_pkg::CSR_VELOCITY, 7'($urandom_range(127)));
         steady = (ph == 2);
         random_events(PHASE_EVENTS);
         settle();
      end
      steady = 1'b0;

      if (errors == 0)
         $display("midi_pad_note_tracker test passed");
      else
         $display("midi_pad_note_tracker test failed");
      $finish;
   end

endmodule
